[hdl/rds_pkg.sv]
// Shared constants and types for the reliable datagram sequencer.
`default_nettype none
package rds_pkg;
   localparam int ID_BITS = 64;
   localparam int CLASS_BITS = 2;
   localparam int KIND_BITS = 2;
   localparam int TAG_PORT_BITS = 16;
   localparam int REORDER_DEPTH_DEF = 16;
   localparam int MISSING_WINDOW_DEF = 64;
   localparam int TAG_BITS_DEF = 16;

   localparam logic [CLASS_BITS-1:0] CLS_UNREL = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLS_SEQ = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLS_REL = 2'd2;
   localparam logic [CLASS_BITS-1:0] CLS_ORD = 2'd3;

   localparam logic [KIND_BITS-1:0] KIND_ACK = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_DELIVER = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DROP = 2'd2;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [CLASS_BITS-1:0] cls;
      logic [ID_BITS-1:0] id;
      logic [TAG_PORT_BITS-1:0] tag;
      logic last;
   } result_type;
endpackage
`default_nettype wire

[hdl/reliable_datagram_sequencer_core.sv]
// Top level of the reliable datagram sequencer.
// One datagram header is taken at a time and the input stalls until the last
// result of the current item has been loaded into the output register. With
// the output free, an item that gives one result or none (unreliable,
// sequenced, reliable ack only, ordered ack only) is accepted, then decided
// and its result loaded. An item that gives two results (reliable ack and
// delivery, ordered ack and delivery, ordered ack and drop) loads its ack
// when decided and its second result after that. An ordered delivery that
// drains buffered entries then loads each drained entry in turn. A stalled
// output holds back a result that is waiting. The reorder window is a
// circular tag memory indexed by (id - 1) modulo REORDER_DEPTH with a
// registered read, so a drain runs one entry per cycle while the output is
// not stalled; valid bits sit in flip-flops and are cleared by reset.
`default_nettype none
module reliable_datagram_sequencer_core
#(
   parameter int REORDER_DEPTH = rds_pkg::REORDER_DEPTH_DEF,
   parameter int MISSING_WINDOW = rds_pkg::MISSING_WINDOW_DEF,
   parameter int TAG_BITS = rds_pkg::TAG_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [rds_pkg::CLASS_BITS-1:0] req_packet_class,
   input wire logic [rds_pkg::ID_BITS-1:0] req_seq_id,
   input wire logic [rds_pkg::TAG_PORT_BITS-1:0] req_payload_tag,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [rds_pkg::KIND_BITS-1:0] rsp_result_kind,
   output logic [rds_pkg::CLASS_BITS-1:0] rsp_result_class,
   output logic [rds_pkg::ID_BITS-1:0] rsp_result_id,
   output logic [rds_pkg::TAG_PORT_BITS-1:0] rsp_result_tag,
   output logic rsp_last
);
   import rds_pkg::*;

   localparam int AW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
   localparam logic [TAG_PORT_BITS-1:0] TAG_MASK =
      (TAG_BITS >= TAG_PORT_BITS) ? {TAG_PORT_BITS{1'b1}}
                                  : TAG_PORT_BITS'((33'd1 << TAG_BITS) - 33'd1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_SECOND = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff;
   logic [CLASS_BITS-1:0] cls_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [TAG_PORT_BITS-1:0] tag_ff;
   logic [ID_BITS-1:0] nseq_ff, nrel_ff, nord_ff;
   logic [MISSING_WINDOW-1:0] miss_ff;
   logic [REORDER_DEPTH-1:0] rvalid_ff;
   logic [AW-1:0] head_ff;
   result_type second_ff;
   logic out_v_ff;
   result_type out_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [TAG_PORT_BITS-1:0] rd_data;
   logic [TAG_PORT_BITS-1:0] tag_trim;

   rds_tag_ram #(.DEPTH(REORDER_DEPTH), .WIDTH(TAG_PORT_BITS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(tag_ff),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Add an offset to a slot, wrapped at the depth
   function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                               input logic [AW:0] b);
      logic [AW+1:0] s;
      begin
         s = {2'b00, a} + {1'b0, b};
         if (s >= (AW+2)'(REORDER_DEPTH)) s = s - (AW+2)'(REORDER_DEPTH);
         slot_add = s[AW-1:0];
      end
   endfunction

   logic out_free;
   logic out_set;
   assign out_free = !out_v_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign tag_trim = req_payload_tag & TAG_MASK;

   // Load the output register whenever the current step has a result for it
   assign out_set = out_free && (((state_ff == ST_DECIDE)
                                  && ((cls_ff != CLS_SEQ) || (id_ff >= nseq_ff)))
                                 || (state_ff == ST_SECOND) || (state_ff == ST_DRAIN));

   // Ordered-window decode of the held id
   logic [ID_BITS-1:0] odiff;
   logic ord_hit, ord_ahead, ord_in_win;
   logic [AW-1:0] odk;
   assign odiff = id_ff - nord_ff;
   assign ord_hit = (id_ff == nord_ff);
   assign ord_ahead = (id_ff > nord_ff);
   assign ord_in_win = (odiff <= ID_BITS'(REORDER_DEPTH));
   assign odk = AW'(odiff - 1);
   assign wr_en = (state_ff == ST_DECIDE) && (cls_ff == CLS_ORD) && ord_ahead
                  && ord_in_win && !rvalid_ff[odk];
   assign wr_addr = slot_add(head_ff, {1'b0, odk});
   // Read the slot of the id expected after this cycle: head while advancing,
   // head-1 while a drain is held
   assign rd_addr = ((state_ff == ST_DRAIN) && !(out_free && !second_ff.last))
                    ? slot_add(head_ff, (AW+1)'(REORDER_DEPTH - 1)) : head_ff;

   // Reliable-window decode
   logic [ID_BITS-1:0] rdiff, rk;
   logic [MISSING_WINDOW-1:0] miss_jump, fill_mask;
   assign rdiff = id_ff - nrel_ff;
   assign rk = nrel_ff - 1 - id_ff;
   always_comb begin
      if (rdiff >= ID_BITS'(MISSING_WINDOW)) begin
         fill_mask = '1;
         fill_mask[0] = 1'b0;
         miss_jump = fill_mask;
      end else begin
         fill_mask = '0;
         for (int i = 1; i < MISSING_WINDOW; i++)
            fill_mask[i] = (ID_BITS'(i) <= rdiff);
         miss_jump = (miss_ff << (rdiff[6:0] + 7'd1)) | fill_mask;
         if (rdiff[6:0] + 7'd1 >= 7'(MISSING_WINDOW))
            miss_jump = fill_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         nseq_ff <= '0;
         nrel_ff <= '0;
         nord_ff <= '0;
         miss_ff <= '0;
         rvalid_ff <= '0;
         head_ff <= '0;
      end else begin
         if (out_set) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DECIDE;
                  cls_ff <= req_packet_class;
                  id_ff <= req_seq_id;
                  tag_ff <= tag_trim;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
                  case (cls_ff)
                     CLS_UNREL: begin
                        out_ff <= '{KIND_DELIVER, CLS_UNREL, '0, tag_ff, 1'b1};
                     end
                     CLS_SEQ: begin
                        if (id_ff >= nseq_ff) begin
                           nseq_ff <= id_ff + 1;
                           out_ff <= '{KIND_DELIVER, CLS_SEQ, id_ff, tag_ff, 1'b1};
                        end
                     end
                     CLS_REL: begin
                        second_ff <= '{KIND_DELIVER, CLS_REL, id_ff, tag_ff, 1'b1};
                        if (id_ff == nrel_ff) begin
                           miss_ff <= miss_ff << 1;
                           nrel_ff <= id_ff + 1;
                           out_ff <= '{KIND_ACK, CLS_REL, id_ff, '0, 1'b0};
                           state_ff <= ST_SECOND;
                        end else if (id_ff > nrel_ff) begin
                           miss_ff <= miss_jump;
                           nrel_ff <= id_ff + 1;
                           out_ff <= '{KIND_ACK, CLS_REL, id_ff, '0, 1'b0};
                           state_ff <= ST_SECOND;
                        end else if (rk < ID_BITS'(MISSING_WINDOW)
                                     && miss_ff[rk[$clog2(MISSING_WINDOW)-1:0]]) begin
                           miss_ff[rk[$clog2(MISSING_WINDOW)-1:0]] <= 1'b0;
                           out_ff <= '{KIND_ACK, CLS_REL, id_ff, '0, 1'b0};
                           state_ff <= ST_SECOND;
                        end else begin
                           out_ff <= '{KIND_ACK, CLS_REL, id_ff, '0, 1'b1};
                        end
                     end
                     default: begin
                        if (ord_hit) begin
                           out_ff <= '{KIND_ACK, CLS_ORD, id_ff, '0, 1'b0};
                           second_ff <= '{KIND_DELIVER, CLS_ORD, id_ff, tag_ff,
                                          !rvalid_ff[0]};
                           nord_ff <= id_ff + 1;
                           state_ff <= rvalid_ff[0] ? ST_DRAIN : ST_SECOND;
                           rvalid_ff <= rvalid_ff >> 1;
                           head_ff <= slot_add(head_ff, (AW+1)'(1));
                        end else if (ord_ahead && !ord_in_win) begin
                           out_ff <= '{KIND_ACK, CLS_ORD, id_ff, '0, 1'b0};
                           second_ff <= '{KIND_DROP, CLS_ORD, id_ff, tag_ff, 1'b1};
                           state_ff <= ST_SECOND;
                        end else begin
                           out_ff <= '{KIND_ACK, CLS_ORD, id_ff, '0, 1'b1};
                           if (ord_ahead && !rvalid_ff[odk]) rvalid_ff[odk] <= 1'b1;
                        end
                     end
                  endcase
               end
            end
            ST_SECOND: begin
               if (out_free) begin
                  out_ff <= second_ff;
                  state_ff <= ST_IDLE;
               end
            end
            ST_DRAIN: begin
               // Emit the pending result; rd_data holds tag of slot head-1
               if (out_free) begin
                  out_ff <= second_ff;
                  if (second_ff.last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     second_ff <= '{KIND_DELIVER, CLS_ORD, nord_ff, rd_data,
                                    !rvalid_ff[0]};
                     nord_ff <= nord_ff + 1;
                     rvalid_ff <= rvalid_ff >> 1;
                     head_ff <= slot_add(head_ff, (AW+1)'(1));
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_result_kind = out_ff.kind;
   assign rsp_result_class = out_ff.cls;
   assign rsp_result_id = out_ff.id;
   assign rsp_result_tag = out_ff.tag;
   assign rsp_last = out_ff.last;
endmodule
`default_nettype wire

[hdl/rds_tag_ram.sv]
// Reorder tag memory: one write port, one registered read port.
`default_nettype none
module rds_tag_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write tag, register read data; slots arrive already wrapped at the depth
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
